// ----- sv/oscm_pkg.sv -----
`default_nettype none

package oscm_pkg;

  // Default speed width and fixed formats
  localparam int unsigned SPEED_BITS_DEF = 16;
  localparam int unsigned WHEEL_BITS     = 16;
  localparam int unsigned GAIN_BITS      = 16;
  localparam int unsigned STEP_LIM_BITS  = 15;
  localparam int unsigned CFG_DATA_BITS  = 16;
  localparam int unsigned CFG_IDX_BITS   = 3;
  localparam int unsigned FRAC_BITS      = 16;  // fraction bits of mix sum times gain
  localparam int unsigned MIX_SAT_EXP    = 46;  // mix sum saturates at +-2^46
  localparam logic [GAIN_BITS-1:0] COS45_Q8 = 16'd181;

  // Sequencer
  localparam int unsigned STEP_BITS = 4;
  localparam logic [STEP_BITS-1:0] STEP_IDLE = 4'd0;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_MAX_STEP_X   = 3'd0,
    REG_MAX_STEP_Y   = 3'd1,
    REG_MAX_STEP_YAW = 3'd2,
    REG_ARM_LENGTH   = 3'd3,
    REG_WHEEL_GAIN   = 3'd4,
    REG_MAX_RPM      = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    AXIS_X   = 2'd0,
    AXIS_Y   = 2'd1,
    AXIS_YAW = 2'd2
  } axis_e;

  typedef enum logic [2:0] {
    MUL_NONE = 3'd0,
    MUL_YAW  = 3'd1,  // applied yaw times arm length
    MUL_DIFF = 3'd2,  // cos45 times (x - y)
    MUL_SUM  = 3'd3,  // cos45 times (x + y)
    MUL_GAIN = 3'd4   // mix sum times wheel gain
  } mul_op_e;

  typedef enum logic {
    SRC_DIFF = 1'b0,
    SRC_SUM  = 1'b1
  } sum_src_e;

  typedef enum logic [1:0] {
    COND_NEXT     = 2'd0,
    COND_WAIT_IN  = 2'd1,  // hold until an item is taken
    COND_WAIT_OUT = 2'd2   // jump to target once the output register is free
  } cond_e;

  typedef struct packed {
    logic                 slew_en;
    axis_e                axis;
    mul_op_e              mul_op;
    logic                 sum_en;
    sum_src_e             sum_src;
    logic                 sum_neg;
    logic                 fin_en;
    logic [1:0]           fin_wheel;
    cond_e                cond;
    logic [STEP_BITS-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic item_in;
    logic out_free;
  } seq_cond_t;

  function automatic ctrl_t ucode(input logic [STEP_BITS-1:0] step);
    ctrl_t w;
    w = '{slew_en: 1'b0, axis: AXIS_X, mul_op: MUL_NONE, sum_en: 1'b0,
          sum_src: SRC_DIFF, sum_neg: 1'b0, fin_en: 1'b0, fin_wheel: 2'd0,
          cond: COND_NEXT, target: STEP_IDLE};
    unique case (step)
      4'd0: w.cond = COND_WAIT_IN;
      4'd1: begin w.slew_en = 1'b1; w.axis = AXIS_X; end
      4'd2: begin w.slew_en = 1'b1; w.axis = AXIS_Y; end
      4'd3: begin w.slew_en = 1'b1; w.axis = AXIS_YAW; end
      4'd4: w.mul_op = MUL_YAW;
      4'd5: w.mul_op = MUL_DIFF;
      4'd6: w.mul_op = MUL_SUM;
      // wheel 0: c(x-y)+Lw
      4'd7: begin w.sum_en = 1'b1; w.sum_src = SRC_DIFF; end
      // wheel 1: -c(x+y)+Lw
      4'd8: begin
        w.mul_op = MUL_GAIN;
        w.sum_en = 1'b1; w.sum_src = SRC_SUM; w.sum_neg = 1'b1;
      end
      // wheel 2: -c(x-y)+Lw
      4'd9: begin
        w.fin_en = 1'b1; w.fin_wheel = 2'd0;
        w.mul_op = MUL_GAIN;
        w.sum_en = 1'b1; w.sum_src = SRC_DIFF; w.sum_neg = 1'b1;
      end
      // wheel 3: c(x+y)+Lw
      4'd10: begin
        w.fin_en = 1'b1; w.fin_wheel = 2'd1;
        w.mul_op = MUL_GAIN;
        w.sum_en = 1'b1; w.sum_src = SRC_SUM;
      end
      4'd11: begin
        w.fin_en = 1'b1; w.fin_wheel = 2'd2;
        w.mul_op = MUL_GAIN;
      end
      4'd12: begin
        w.fin_en = 1'b1; w.fin_wheel = 2'd3;
        w.cond = COND_WAIT_OUT; w.target = STEP_IDLE;
      end
      default: w.cond = COND_NEXT;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- sv/oscm_seq.sv -----
`default_nettype none

module oscm_seq (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire oscm_pkg::seq_cond_t cond_i,
  output oscm_pkg::ctrl_t        ctrl_o,
  output logic [oscm_pkg::STEP_BITS-1:0] step_o
);

  logic [oscm_pkg::STEP_BITS-1:0] step_q, step_d;

  assign ctrl_o = oscm_pkg::ucode(step_q);
  assign step_o = step_q;

  always_comb begin
    step_d = step_q + 1'b1;
    unique case (ctrl_o.cond)
      oscm_pkg::COND_WAIT_IN:  if (!cond_i.item_in) step_d = step_q;
      oscm_pkg::COND_WAIT_OUT: step_d = cond_i.out_free ? ctrl_o.target : step_q;
      default:                 step_d = step_q + 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= oscm_pkg::STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/omni_chassis_slew_mixer_core.sv -----
// A microcoded sequence of 13 steps drives one shared multiplier (slew per axis, three
// mix products, then gain and rounding per wheel); a new item is taken only in the idle step.
// A new item is taken while the previous result still waits in the output register.
// Reset (async, active low) zeros the applied speeds, loads the register defaults
// and empties the output register.
`default_nettype none

module omni_chassis_slew_mixer_core #(
  parameter int unsigned SPEED_BITS = oscm_pkg::SPEED_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  // target_x_speed, target_y_speed, target_yaw_speed
  input  wire logic [((3*SPEED_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  // wheel_rpm_0..3, applied_x_speed, applied_y_speed, applied_yaw_speed
  output logic [((4*oscm_pkg::WHEEL_BITS+3*SPEED_BITS+7)/8)*8-1:0] m_axis_tdata,
  input  wire logic cfg_we_i,
  input  wire logic [oscm_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  wire logic [oscm_pkg::CFG_DATA_BITS-1:0] cfg_wdata_i
);

  localparam int unsigned SB    = SPEED_BITS;
  localparam int unsigned WB    = oscm_pkg::WHEEL_BITS;
  localparam int unsigned GB    = oscm_pkg::GAIN_BITS;
  localparam int unsigned LB    = oscm_pkg::STEP_LIM_BITS;
  localparam int unsigned OUT_W = ((4*WB+3*SB+7)/8)*8;
  localparam int unsigned CW    = ((SB+1 > LB+1) ? SB+1 : LB+1) + 1;  // slew compare
  localparam int unsigned TW    = SB + GB;      // yaw term
  localparam int unsigned DW    = SB + 9;       // cos45 products
  localparam int unsigned SSW   = SB + GB + 1;  // full mix sum
  localparam int unsigned EXW   = (SSW > oscm_pkg::MIX_SAT_EXP + 2) ? SSW
                                                                   : oscm_pkg::MIX_SAT_EXP + 2;
  localparam int unsigned AW    = (SSW < oscm_pkg::MIX_SAT_EXP + 2) ? SSW
                                                                   : oscm_pkg::MIX_SAT_EXP + 2;
  localparam int unsigned PW    = AW + GB;      // mix sum times gain
  localparam int unsigned MW    = PW + 1 - oscm_pkg::FRAC_BITS;

  localparam logic signed [EXW-1:0] MIX_SAT =
    {{(EXW-oscm_pkg::MIX_SAT_EXP-1){1'b0}}, 1'b1, {oscm_pkg::MIX_SAT_EXP{1'b0}}};
  localparam logic [PW:0] RND_HALF = (PW+1)'(1) << (oscm_pkg::FRAC_BITS - 1);

  // Configuration
  logic [LB-1:0] max_step_x_q, max_step_y_q, max_step_yaw_q, max_rpm_q;
  logic [GB-1:0] arm_length_q, wheel_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_step_x_q   <= LB'(100);
      max_step_y_q   <= LB'(100);
      max_step_yaw_q <= LB'(100);
      arm_length_q   <= GB'(256);
      wheel_gain_q   <= GB'(256);
      max_rpm_q      <= LB'(9000);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        oscm_pkg::REG_MAX_STEP_X:   max_step_x_q   <= cfg_wdata_i[LB-1:0];
        oscm_pkg::REG_MAX_STEP_Y:   max_step_y_q   <= cfg_wdata_i[LB-1:0];
        oscm_pkg::REG_MAX_STEP_YAW: max_step_yaw_q <= cfg_wdata_i[LB-1:0];
        oscm_pkg::REG_ARM_LENGTH:   arm_length_q   <= cfg_wdata_i[GB-1:0];
        oscm_pkg::REG_WHEEL_GAIN:   wheel_gain_q   <= cfg_wdata_i[GB-1:0];
        oscm_pkg::REG_MAX_RPM:      max_rpm_q      <= cfg_wdata_i[LB-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  oscm_pkg::ctrl_t     ctrl;
  oscm_pkg::seq_cond_t seq_cond;
  logic [oscm_pkg::STEP_BITS-1:0] step;
  logic in_acc, out_free;

  assign s_axis_tready     = (ctrl.cond == oscm_pkg::COND_WAIT_IN);
  assign in_acc            = s_axis_tvalid && s_axis_tready;
  assign out_free          = !m_axis_tvalid || m_axis_tready;
  assign seq_cond.item_in  = in_acc;
  assign seq_cond.out_free = out_free;

  oscm_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cond_i (seq_cond),
    .ctrl_o (ctrl),
    .step_o (step)
  );

  // Targets
  logic signed [SB-1:0] tgt_x_q, tgt_y_q, tgt_w_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      tgt_x_q <= s_axis_tdata[SB-1:0];
      tgt_y_q <= s_axis_tdata[2*SB-1:SB];
      tgt_w_q <= s_axis_tdata[3*SB-1:2*SB];
    end
  end

  // Slew limiter, one axis per step
  logic signed [SB-1:0] prev_x_q, prev_y_q, prev_w_q;
  logic signed [SB-1:0] sl_tgt, sl_prev, sl_res;
  logic [LB-1:0]        sl_step;
  logic signed [CW-1:0] sl_d, sl_lim, sl_dl;

  always_comb begin
    case (ctrl.axis)
      oscm_pkg::AXIS_X: begin
        sl_tgt = tgt_x_q; sl_prev = prev_x_q; sl_step = max_step_x_q;
      end
      oscm_pkg::AXIS_Y: begin
        sl_tgt = tgt_y_q; sl_prev = prev_y_q; sl_step = max_step_y_q;
      end
      default: begin
        sl_tgt = tgt_w_q; sl_prev = prev_w_q; sl_step = max_step_yaw_q;
      end
    endcase
    sl_d   = CW'(sl_tgt) - CW'(sl_prev);
    sl_lim = CW'({1'b0, sl_step});
    if (sl_d > sl_lim) begin
      sl_dl = sl_lim;
    end else if (sl_d < -sl_lim) begin
      sl_dl = -sl_lim;
    end else begin
      sl_dl = sl_d;
    end
    sl_res = sl_prev + sl_dl[SB-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q <= '0;
      prev_y_q <= '0;
      prev_w_q <= '0;
    end else if (ctrl.slew_en) begin
      case (ctrl.axis)
        oscm_pkg::AXIS_X: prev_x_q <= sl_res;
        oscm_pkg::AXIS_Y: prev_y_q <= sl_res;
        default:          prev_w_q <= sl_res;
      endcase
    end
  end

  // Shared multiplier: signed operand times unsigned 16-bit coefficient
  logic signed [SB:0]     xy_diff, xy_sum;
  logic signed [AW-1:0]   mul_a;
  logic [GB-1:0]          mul_b;
  logic signed [AW+GB:0]  prod;
  logic signed [TW-1:0]   t_q;
  logic signed [DW-1:0]   d_q, e_q;
  logic signed [AW-1:0]   s_q;
  logic signed [PW-1:0]   p_q;

  assign xy_diff = (SB+1)'(prev_x_q) - (SB+1)'(prev_y_q);
  assign xy_sum  = (SB+1)'(prev_x_q) + (SB+1)'(prev_y_q);

  always_comb begin
    case (ctrl.mul_op)
      oscm_pkg::MUL_YAW:  begin mul_a = AW'(prev_w_q); mul_b = arm_length_q;       end
      oscm_pkg::MUL_DIFF: begin mul_a = AW'(xy_diff);  mul_b = oscm_pkg::COS45_Q8; end
      oscm_pkg::MUL_SUM:  begin mul_a = AW'(xy_sum);   mul_b = oscm_pkg::COS45_Q8; end
      oscm_pkg::MUL_GAIN: begin mul_a = s_q;           mul_b = wheel_gain_q;       end
      default:            begin mul_a = '0;            mul_b = '0;                 end
    endcase
    prod = mul_a * signed'({1'b0, mul_b});
  end

  always_ff @(posedge clk_i) begin
    case (ctrl.mul_op)
      oscm_pkg::MUL_YAW:  t_q <= prod[TW-1:0];
      oscm_pkg::MUL_DIFF: d_q <= prod[DW-1:0];
      oscm_pkg::MUL_SUM:  e_q <= prod[DW-1:0];
      oscm_pkg::MUL_GAIN: p_q <= prod[PW-1:0];
      default: ;
    endcase
  end

  // Mix sum with saturation at +-2^46
  logic signed [SSW-1:0] sum_op, sum_full;
  logic signed [EXW-1:0] sum_ext, sum_sat;

  always_comb begin
    sum_op = (ctrl.sum_src == oscm_pkg::SRC_SUM) ? SSW'(e_q) : SSW'(d_q);
    if (ctrl.sum_neg) begin
      sum_op = -sum_op;
    end
    sum_full = sum_op + SSW'(t_q);
    sum_ext  = EXW'(sum_full);
    if (sum_ext > MIX_SAT) begin
      sum_sat = MIX_SAT;
    end else if (sum_ext < -MIX_SAT) begin
      sum_sat = -MIX_SAT;
    end else begin
      sum_sat = sum_ext;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.sum_en) begin
      s_q <= sum_sat[AW-1:0];
    end
  end

  // Round half away from zero, then clamp to +-max_rpm
  logic          p_neg;
  logic [PW-1:0] p_mag;
  logic [PW:0]   p_rnd;
  logic [MW-1:0] p_int;
  logic [LB-1:0] r_mag;
  logic [WB-1:0] fin_val;
  logic [WB-1:0] wheel_q [4];

  always_comb begin
    p_neg = p_q[PW-1];
    p_mag = p_neg ? PW'(-p_q) : PW'(p_q);
    p_rnd = {1'b0, p_mag} + RND_HALF;
    p_int = p_rnd[PW:oscm_pkg::FRAC_BITS];
    if (p_int > MW'(max_rpm_q)) begin
      r_mag = max_rpm_q;
    end else begin
      r_mag = p_int[LB-1:0];
    end
    fin_val = p_neg ? -{1'b0, r_mag} : {1'b0, r_mag};
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.fin_en) begin
      wheel_q[ctrl.fin_wheel] <= fin_val;
    end
  end

  // Output register; the last step delivers wheel 3 straight from the rounding logic
  logic             out_load;
  logic             out_valid_q;
  logic [OUT_W-1:0] out_data_q;

  assign out_load = (ctrl.cond == oscm_pkg::COND_WAIT_OUT) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= OUT_W'({prev_w_q, prev_y_q, prev_x_q,
                            fin_val, wheel_q[2], wheel_q[1], wheel_q[0]});
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Checks
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (step == oscm_pkg::STEP_IDLE + 1'b1))
    else $error("accepted item did not start the sequence");

  a_load_completes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (m_axis_tvalid && s_axis_tready))
    else $error("result load did not return to idle with a valid result");

  a_valid_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(ctrl.cond == oscm_pkg::COND_WAIT_OUT))
    else $error("result appeared outside the final step");

endmodule

`default_nettype wire
